@@ sv/rdq_pkg.sv @@
// rdq_pkg: shared types and codes for the record deque with key search
// no dependencies

package rdq_pkg;

  localparam int KeyW   = 32;
  localparam int DateW  = 27;
  localparam int OpW    = 3;
  localparam int StatW  = 2;
  localparam int EcountW = 7;

  localparam logic [OpW-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OpW-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OpW-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OpW-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OpW-1:0] OP_SEARCH     = 3'd4;

  localparam logic [StatW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatW-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [StatW-1:0] STAT_FULL      = 2'd2;
  localparam logic [StatW-1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [DateW-1:0]       date;
  } rec_t;

  typedef struct packed {
    logic shift_left;
    logic shift_right;
  } ring_ctl_t;

endpackage

@@ sv/rdq_cell.sv @@
// rdq_cell: one record slot of the ring, moves its record to either neighbor
// depends on rdq_pkg

module rdq_cell (
  input  logic              clk,
  input  rdq_pkg::ring_ctl_t ctl,
  input  rdq_pkg::rec_t     left_in,
  input  rdq_pkg::rec_t     right_in,
  output rdq_pkg::rec_t     rec_out
);

  rdq_pkg::rec_t rec_r;
  rdq_pkg::rec_t rec_nxt;

  always_comb begin
    rec_nxt = rec_r;
    if (ctl.shift_left) begin
      rec_nxt = right_in;
    end else if (ctl.shift_right) begin
      rec_nxt = left_in;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec_out = rec_r;

endmodule

@@ sv/record_deque_with_key_search_core.sv @@
// record_deque_with_key_search_core: bounded deque of records in a ring of cells
// depends on rdq_pkg and rdq_cell
//
// The records sit in a ring of DEPTH cells with the front record always in cell 0.
// Push front, pop front, the spare op codes, a push to a full store and a pop or a
// search on an empty store take no turn of the ring: the word passes the busy state
// and the done state, where its result is written to the output register. Push back,
// pop back and search on a non-empty store rotate the ring one place per cycle through
// a full turn of DEPTH steps, so every record passes cell 0, where it is compared or
// captured, and the back slot passes the tail cell, where a pushed record is written;
// the ring is back in place at the end. These give their result from the done state
// after the turn. One operation is worked on at a time; a finished result waits in the
// output register while the next word is taken in, and when that register is still
// unread the following result waits in the core, which then holds off its input.

module record_deque_with_key_search_core #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // patient_key[31:0], birth_date[58:32], zeros
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // out_key[31:0], out_birth_date[58:32],
                                  // entry_count[65:59], zeros
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [rdq_pkg::OpW-1:0] op_r, op_nxt;
  rdq_pkg::rec_t in_rec_r, in_rec_nxt;
  rdq_pkg::rec_t res_r, res_nxt;
  logic hit_r, hit_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [rdq_pkg::StatW-1:0] out_status_r, out_status_nxt;
  rdq_pkg::rec_t out_rec_r, out_rec_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;

  rdq_pkg::ring_ctl_t ctl;
  rdq_pkg::rec_t cell_q [DEPTH];
  rdq_pkg::rec_t tail_in;
  rdq_pkg::rec_t front_in;
  rdq_pkg::rec_t zero_rec;

  logic full, empty, sweep_op, out_free, in_acc, step_last;
  logic [CW-1:0] step_ext;

  assign zero_rec = '0;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign step_ext = CW'(step_r);
  assign step_last = (step_r == SW'(DEPTH - 1));
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign front_in = in_rec_r;

  always_comb begin
    case (op_r)
      rdq_pkg::OP_PUSH_BACK: sweep_op = !full;
      rdq_pkg::OP_POP_BACK:  sweep_op = !empty;
      rdq_pkg::OP_SEARCH:    sweep_op = !empty;
      default:               sweep_op = 1'b0;
    endcase
  end

  // ring of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rdq_pkg::rec_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = front_in;
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = tail_in;
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end
    rdq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .left_in  (left_w),
      .right_in (right_w),
      .rec_out  (cell_q[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    in_rec_nxt     = in_rec_r;
    res_nxt        = res_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    out_count_nxt  = out_count_r;
    ctl            = '0;
    tail_in        = cell_q[0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt         = in_tuser;
          in_rec_nxt.key  = in_tdata[31:0];
          in_rec_nxt.date = in_tdata[58:32];
          hit_nxt        = 1'b0;
          res_nxt        = zero_rec;
          step_nxt       = '0;
          state_nxt      = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (sweep_op) begin
          ctl.shift_left = 1'b1;
          step_nxt       = step_r + SW'(1);
          // back slot reaches the tail as the ring turns
          if (op_r == rdq_pkg::OP_PUSH_BACK && step_ext == count_r) begin
            tail_in = in_rec_r;
          end
          if (op_r == rdq_pkg::OP_POP_BACK && step_ext == count_r - CW'(1)) begin
            res_nxt = cell_q[0];
          end
          if (op_r == rdq_pkg::OP_SEARCH && !hit_r && step_ext < count_r
              && cell_q[0].key == in_rec_r.key) begin
            res_nxt = cell_q[0];
            hit_nxt = 1'b1;
          end
          if (step_last) begin
            state_nxt = ST_DONE;
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rdq_pkg::STAT_OK;
          out_rec_nxt    = zero_rec;
          case (op_r)
            rdq_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                out_status_nxt = rdq_pkg::STAT_FULL;
              end else begin
                ctl.shift_right = 1'b1;
                count_nxt       = count_r + CW'(1);
              end
            end
            rdq_pkg::OP_PUSH_BACK: begin
              if (full) begin
                out_status_nxt = rdq_pkg::STAT_FULL;
              end else begin
                count_nxt = count_r + CW'(1);
              end
            end
            rdq_pkg::OP_POP_FRONT: begin
              if (empty) begin
                out_status_nxt = rdq_pkg::STAT_EMPTY;
              end else begin
                ctl.shift_left = 1'b1;
                out_rec_nxt    = cell_q[0];
                count_nxt      = count_r - CW'(1);
              end
            end
            rdq_pkg::OP_POP_BACK: begin
              if (empty) begin
                out_status_nxt = rdq_pkg::STAT_EMPTY;
              end else begin
                out_rec_nxt = res_r;
                count_nxt   = count_r - CW'(1);
              end
            end
            rdq_pkg::OP_SEARCH: begin
              if (hit_r) begin
                out_rec_nxt = res_r;
              end else begin
                out_status_nxt = rdq_pkg::STAT_NOT_FOUND;
              end
            end
            default: begin
              out_status_nxt = rdq_pkg::STAT_OK;
            end
          endcase
          out_count_nxt = count_nxt;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      hit_r       <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    in_rec_r     <= in_rec_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_rec_r    <= out_rec_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'b0, rdq_pkg::EcountW'(out_count_r), out_rec_r.date, out_rec_r.key};

endmodule

@@ tb/rdq_result_checker.sv @@
// rdq_result_checker: watches both streams of the record deque, predicts each result word
// and compares it field by field with what the core returns
// depends on rdq_pkg

module rdq_result_checker #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // patient_key[31:0], birth_date[58:32], zeros
  input  logic [2:0]  in_tuser,   // op[2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,  // out_key[31:0], out_birth_date[58:32],
                                  // entry_count[65:59], zeros
  input  logic [1:0]  out_tuser,  // status[1:0]
  output int          mismatch_count,
  output int          results_waiting,
  output int          full_hits,
  output int          empty_hits,
  output int          found_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [rdq_pkg::StatW-1:0]       status;
    logic signed [rdq_pkg::KeyW-1:0] key;
    logic [rdq_pkg::DateW-1:0]       date;
    logic [rdq_pkg::EcountW-1:0]     count;
  } outcome_t;

  rdq_pkg::rec_t ring [DEPTH];
  int unsigned   front_slot;
  int unsigned   held;
  outcome_t      expected_q [$];
  int            errors;
  int            fulls;
  int            empties;
  int            founds;

  function automatic int unsigned slot_after(int unsigned pos);
    return (front_slot + pos) % DEPTH;
  endfunction

  task automatic deque_apply(input logic [rdq_pkg::OpW-1:0] op,
                             input logic [rdq_pkg::KeyW-1:0] key,
                             input logic [rdq_pkg::DateW-1:0] date, output outcome_t res);
    int unsigned s;
    int unsigned i;
    logic        hit;
    res        = '0;
    res.status = rdq_pkg::STAT_OK;
    hit        = 1'b0;
    case (op)
      rdq_pkg::OP_PUSH_FRONT: begin
        if (held >= DEPTH) begin
          res.status = rdq_pkg::STAT_FULL;
        end else begin
          front_slot = (front_slot == 0) ? DEPTH - 1 : front_slot - 1;
          ring[front_slot] = '{key: key, date: date};
          held++;
        end
      end
      rdq_pkg::OP_PUSH_BACK: begin
        if (held >= DEPTH) begin
          res.status = rdq_pkg::STAT_FULL;
        end else begin
          ring[slot_after(held)] = '{key: key, date: date};
          held++;
        end
      end
      rdq_pkg::OP_POP_FRONT: begin
        if (held == 0) begin
          res.status = rdq_pkg::STAT_EMPTY;
        end else begin
          res.key    = ring[front_slot].key;
          res.date   = ring[front_slot].date;
          front_slot = slot_after(1);
          held--;
        end
      end
      rdq_pkg::OP_POP_BACK: begin
        if (held == 0) begin
          res.status = rdq_pkg::STAT_EMPTY;
        end else begin
          s        = slot_after(held - 1);
          res.key  = ring[s].key;
          res.date = ring[s].date;
          held--;
        end
      end
      rdq_pkg::OP_SEARCH: begin
        res.status = rdq_pkg::STAT_NOT_FOUND;
        for (i = 0; i < held && !hit; i++) begin
          s = slot_after(i);
          if (ring[s].key == key) begin
            hit        = 1'b1;
            res.status = rdq_pkg::STAT_OK;
            res.key    = ring[s].key;
            res.date   = ring[s].date;
          end
        end
      end
      default: begin
      end
    endcase
    res.count = rdq_pkg::EcountW'(held);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    outcome_t res;
    if (!rst_n) begin
      front_slot = 0;
      held       = 0;
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{status: out_tuser, key: out_tdata[31:0], date: out_tdata[58:32],
                count: out_tdata[65:59]};
        if (expected_q.size() == 0) begin
          $display("%0t ns: result word with nothing expected, expected none, actual %p",
                   $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("out_key", want.key, got.key);
          check_field("out_birth_date", 32'(want.date), 32'(got.date));
          check_field("entry_count", 32'(want.count), 32'(got.count));
        end
      end
      if (in_tvalid && in_tready) begin
        deque_apply(in_tuser, in_tdata[31:0], in_tdata[58:32], res);
        case (res.status)
          rdq_pkg::STAT_FULL:  fulls++;
          rdq_pkg::STAT_EMPTY: empties++;
          default: begin
            if (in_tuser == rdq_pkg::OP_SEARCH && res.status == rdq_pkg::STAT_OK) founds++;
          end
        endcase
        expected_q.push_back(res);
      end
    end
    results_waiting <= expected_q.size();
    mismatch_count  <= errors;
    full_hits       <= fulls;
    empty_hits      <= empties;
    found_hits      <= founds;
  end

endmodule

@@ tb/tb_record_deque_with_key_search_core.sv @@
// tb_record_deque_with_key_search_core: drives push, pop and search words into the core
// with random gaps and stalls, and gives the verdict from rdq_result_checker's count
// depends on rdq_pkg, record_deque_with_key_search_core and rdq_result_checker

module tb_record_deque_with_key_search_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 64;
  localparam int ITEMS       = 1000;
  localparam int PHASE_LEN   = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [rdq_pkg::OpW-1:0] OP_SPARE_FIRST = rdq_pkg::OP_SEARCH + 3'd1;
  localparam logic [rdq_pkg::OpW-1:0] OP_SPARE_LAST  = 3'd7;

  typedef enum {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // patient_key[31:0], birth_date[58:32], zeros
  logic [2:0]  in_tuser;   // op[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // out_key[31:0], out_birth_date[58:32], entry_count[65:59], zeros
  logic [1:0]  out_tuser;  // status[1:0]

  int   mismatch_count;
  int   results_waiting;
  int   full_hits;
  int   empty_hits;
  int   found_hits;
  int   cycle_count;
  int   hold_requests;
  int   hold_served;
  logic quiet;
  int   words_by_op [8];

  record_deque_with_key_search_core #(.DEPTH(DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rdq_result_checker #(.DEPTH(DEPTH)) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .mismatch_count  (mismatch_count),
    .results_waiting (results_waiting),
    .full_hits       (full_hits),
    .empty_hits      (empty_hits),
    .found_hits      (found_hits)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results still due", cycle_count,
                 results_waiting);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // receiver: random stalls, quiet stretch, and long hold-offs on request
  initial begin
    hold_served = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served < hold_requests) begin
        hold_served++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= quiet || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  function automatic logic [rdq_pkg::KeyW-1:0] draw_key();
    if ($urandom_range(0, 99) < 60) begin
      return rdq_pkg::KeyW'($signed($urandom_range(0, 15)) - 8);
    end
    return $urandom();
  endfunction

  function automatic logic [rdq_pkg::DateW-1:0] draw_date();
    if ($urandom_range(0, 1) == 0) begin
      return rdq_pkg::DateW'($urandom_range(19000101, 20991231));
    end
    return rdq_pkg::DateW'($urandom());
  endfunction

  function automatic logic [rdq_pkg::OpW-1:0] draw_op(mix_t mix);
    int roll;
    int push_w;
    int pop_w;
    roll   = $urandom_range(0, 99);
    push_w = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 10 : 35;
    pop_w  = (mix == MIX_FILL) ? 10 : (mix == MIX_DRAIN) ? 70 : 35;
    if (roll < 5) return OP_SPARE_FIRST + rdq_pkg::OpW'($urandom_range(0, 2));
    if (roll < 5 + push_w) begin
      return $urandom_range(0, 1) ? rdq_pkg::OP_PUSH_FRONT : rdq_pkg::OP_PUSH_BACK;
    end
    if (roll < 5 + push_w + pop_w) begin
      return $urandom_range(0, 1) ? rdq_pkg::OP_POP_FRONT : rdq_pkg::OP_POP_BACK;
    end
    return rdq_pkg::OP_SEARCH;
  endfunction

  task automatic send_word(input logic [rdq_pkg::OpW-1:0] op,
                           input logic [rdq_pkg::KeyW-1:0] key,
                           input logic [rdq_pkg::DateW-1:0] date);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, date, key};
    words_by_op[op]++;
    do @(posedge clk); while (!in_tready);
    if (!quiet && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (results_waiting != 0);
  endtask

  initial begin
    int       counted;
    int       spare;
    logic     hold_done;
    logic     pause_done;
    mix_t     mix;
    logic [rdq_pkg::OpW-1:0] op;
    counted       = 0;
    hold_done     = 1'b0;
    pause_done    = 1'b0;
    hold_requests = 0;
    quiet         = 1'b0;
    foreach (words_by_op[i]) words_by_op[i] = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= rdq_pkg::OP_PUSH_FRONT;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store, extremes of key and date, duplicates, spare codes
    send_word(rdq_pkg::OP_POP_FRONT, 32'h0, 27'h0);
    send_word(rdq_pkg::OP_POP_BACK, 32'hFFFF_FFFF, 27'h7FF_FFFF);
    send_word(rdq_pkg::OP_SEARCH, 32'h0, 27'h0);
    send_word(rdq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF, 27'h0);
    send_word(rdq_pkg::OP_PUSH_BACK, 32'h8000_0000, 27'h7FF_FFFF);
    send_word(rdq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 27'd99999999);
    send_word(rdq_pkg::OP_PUSH_BACK, 32'h0, 27'd19700101);
    send_word(rdq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF, 27'd20240229);
    send_word(rdq_pkg::OP_SEARCH, 32'hFFFF_FFFF, 27'h0);
    send_word(rdq_pkg::OP_SEARCH, 32'h8000_0000, 27'h7FF_FFFF);
    send_word(rdq_pkg::OP_SEARCH, 32'd12345, 27'h0);
    send_word(rdq_pkg::OP_SEARCH, 32'h0, 27'h0);
    for (spare = OP_SPARE_FIRST; spare <= OP_SPARE_LAST; spare++) begin
      send_word(rdq_pkg::OpW'(spare), 32'hFFFF_FFFF, 27'h7FF_FFFF);
    end
    send_word(rdq_pkg::OP_POP_BACK, 32'h0, 27'h0);
    send_word(rdq_pkg::OP_POP_FRONT, 32'h0, 27'h0);
    send_word(rdq_pkg::OP_POP_FRONT, 32'h0, 27'h0);
    send_word(rdq_pkg::OP_POP_BACK, 32'h0, 27'h0);
    send_word(rdq_pkg::OP_POP_BACK, 32'h0, 27'h0);
    send_word(rdq_pkg::OP_POP_FRONT, 32'h0, 27'h0);
    send_word(rdq_pkg::OP_SEARCH, 32'hFFFF_FFFF, 27'h0);

    while (counted < ITEMS) begin
      case ((counted / PHASE_LEN) % 4)
        0:       mix = MIX_FILL;
        2:       mix = MIX_DRAIN;
        default: mix = MIX_EVEN;
      endcase
      quiet = (counted >= 450 && counted < 600);
      if (counted == 300 && !hold_done) begin
        hold_done = 1'b1;
        hold_requests++;
      end
      if (counted == 750 && !pause_done) begin
        pause_done = 1'b1;
        in_tvalid <= 1'b0;
        wait_drained();
      end
      op = draw_op(mix);
      if (op < OP_SPARE_FIRST) counted++;
      send_word(op, draw_key(), draw_date());
    end
    in_tvalid <= 1'b0;
    quiet = 1'b0;

    wait_drained();
    repeat (2 * DEPTH + 16) @(posedge clk);

    $display("%0d words: %0d push front, %0d push back, %0d pop front, %0d pop back, %0d search",
             words_by_op.sum(), words_by_op[rdq_pkg::OP_PUSH_FRONT],
             words_by_op[rdq_pkg::OP_PUSH_BACK], words_by_op[rdq_pkg::OP_POP_FRONT],
             words_by_op[rdq_pkg::OP_POP_BACK], words_by_op[rdq_pkg::OP_SEARCH]);
    $display("refused when full %0d, popped when empty %0d, searches that hit %0d",
             full_hits, empty_hits, found_hits);
    if (mismatch_count == 0 && results_waiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rdq_pkg.sv
sv/rdq_cell.sv
sv/record_deque_with_key_search_core.sv
tb/rdq_result_checker.sv
tb/tb_record_deque_with_key_search_core.sv
